// File: hw/rtl/dwsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwsp_pkg
// Shared types and constants of the dual wheel PI speed controller.
// ----------------------------------------------------------------------------
package dwsp_pkg;

  localparam int SPEED_W = 16;
  localparam int ERR_W   = SPEED_W + 1;
  localparam int STEP_W  = 16;
  localparam int LIMIT_W = 25;
  localparam int INTEG_W = LIMIT_W + 1;
  localparam int GAIN_W  = 16;
  localparam int PWM_W   = 8;
  localparam int DRIVE_W = 16;
  localparam int CFG_W   = LIMIT_W;
  localparam int IDX_W   = 3;

  // Shared multiplier operand widths: integrator by gain, both signed.
  localparam int MUL_A_W = INTEG_W;
  localparam int MUL_B_W = GAIN_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Integrator sum before the clamp, and the drive sum with 32 fraction bits.
  localparam int ACC_W   = 35;
  localparam int SUM_W   = 52;
  localparam int RMAG_W  = SUM_W - 32;

  localparam logic [SUM_W-1:0] HALF_LSB = SUM_W'(64'h8000_0000);

  localparam logic [STEP_W-1:0]  STEP_TIME_RST = 16'd1311;
  localparam logic [LIMIT_W-1:0] LIMIT_RST     = 25'd31457280;
  localparam logic [GAIN_W-1:0]  GAIN_RST      = 16'd4096;
  localparam logic [PWM_W-1:0]   CEILING_RST   = 8'd255;

  typedef enum logic [IDX_W-1:0] {
    REG_STEP_TIME  = 3'd0,
    REG_INT_LIMIT  = 3'd1,
    REG_GAIN_P     = 3'd2,
    REG_GAIN_I     = 3'd3,
    REG_BASE_LEFT  = 3'd4,
    REG_BASE_RIGHT = 3'd5,
    REG_PWM_FLOOR  = 3'd6,
    REG_PWM_CEIL   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [STEP_W-1:0]  step_time;
    logic [LIMIT_W-1:0] integral_limit;
    logic [GAIN_W-1:0]  gain_proportional;
    logic [GAIN_W-1:0]  gain_integral;
    logic [PWM_W-1:0]   base_left;
    logic [PWM_W-1:0]   base_right;
    logic [PWM_W-1:0]   pwm_floor;
    logic [PWM_W-1:0]   pwm_ceiling;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_STEP,
    ST_INTEG,
    ST_CLAMP,
    ST_MUL_INT,
    ST_ADD_INT,
    ST_ROUND,
    ST_SAT,
    ST_DONE
  } state_t;

  typedef struct packed {
    state_t phase;
    logic   wheel;     // 0 = left, 1 = right
    logic   busy;
    logic   load_out;
  } ctrl_t;

endpackage

// File: hw/rtl/dwsp_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwsp_cfg
// Configuration register file with write-only access by register index.
// ----------------------------------------------------------------------------
module dwsp_cfg
  import dwsp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_time         <= STEP_TIME_RST;
      cfg.integral_limit    <= LIMIT_RST;
      cfg.gain_proportional <= GAIN_RST;
      cfg.gain_integral     <= GAIN_RST;
      cfg.base_left         <= '0;
      cfg.base_right        <= '0;
      cfg.pwm_floor         <= '0;
      cfg.pwm_ceiling       <= CEILING_RST;
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_STEP_TIME:  cfg.step_time         <= cfg_data[STEP_W-1:0];
        REG_INT_LIMIT:  cfg.integral_limit    <= cfg_data[LIMIT_W-1:0];
        REG_GAIN_P:     cfg.gain_proportional <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I:     cfg.gain_integral     <= cfg_data[GAIN_W-1:0];
        REG_BASE_LEFT:  cfg.base_left         <= cfg_data[PWM_W-1:0];
        REG_BASE_RIGHT: cfg.base_right        <= cfg_data[PWM_W-1:0];
        REG_PWM_FLOOR:  cfg.pwm_floor         <= cfg_data[PWM_W-1:0];
        REG_PWM_CEIL:   cfg.pwm_ceiling       <= cfg_data[PWM_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: hw/rtl/dwsp_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwsp_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module dwsp_mul
  import dwsp_pkg::*;
(
  input  logic                     clk,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [PROD_W-1:0]  prod
);

  always_ff @(posedge clk) begin
    prod <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

// File: hw/rtl/dwsp_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwsp_seq
// Sequencer that walks both wheels through the shared multiplier.
// ----------------------------------------------------------------------------
module dwsp_seq
  import dwsp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  out_free,
  output ctrl_t ctrl
);

  state_t state, state_next;
  logic   wheel, wheel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      wheel <= 1'b0;
    end else begin
      state <= state_next;
      wheel <= wheel_next;
    end
  end

  always_comb begin
    state_next = state;
    wheel_next = wheel;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_MUL_STEP;
          wheel_next = 1'b0;
        end
      end
      ST_MUL_STEP: state_next = ST_INTEG;
      ST_INTEG:    state_next = ST_CLAMP;
      ST_CLAMP:    state_next = ST_MUL_INT;
      ST_MUL_INT:  state_next = ST_ADD_INT;
      ST_ADD_INT:  state_next = ST_ROUND;
      ST_ROUND:    state_next = ST_SAT;
      ST_SAT: begin
        if (wheel) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_MUL_STEP;
          wheel_next = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl.phase    = state;
    ctrl.wheel    = wheel;
    ctrl.busy     = (state != ST_IDLE);
    ctrl.load_out = (state == ST_DONE) && out_free;
  end

endmodule

// File: hw/rtl/dual_wheel_speed_pi.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_wheel_speed_pi
// Two-wheel PI speed controller with feedforward, stall reset of the
// integrator and anti-windup clamp, built around one shared multiplier.
// ----------------------------------------------------------------------------
// Each wheel takes seven steps of the sequencer through the single shared
// multiplier, the left wheel first and then the right. A done state then
// loads the output register, waiting while the output stalls, and the idle
// state accepts the next item; no new item is taken before the last is out.
// Input stall stays high until the result is written to the output register.
// Reset (rst, synchronous) loads register defaults and zeroes both integrators.
module dual_wheel_speed_pi
  import dwsp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [SPEED_W-1:0] target_left,
  input  logic signed [SPEED_W-1:0] target_right,
  input  logic signed [SPEED_W-1:0] measured_left,
  input  logic signed [SPEED_W-1:0] measured_right,
  input  logic                      left_no_edges,
  input  logic                      right_no_edges,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [DRIVE_W-1:0] drive_left,
  output logic signed [DRIVE_W-1:0] drive_right
);

  cfg_t  cfg;
  ctrl_t ctrl;
  logic  in_fire;
  logic  out_free;

  logic signed [ERR_W-1:0]   err_l, err_r, err_s;
  logic                      moving_l, moving_r, moving_s;
  logic                      clear_l, clear_r, clear_s;
  logic signed [INTEG_W-1:0] integ_l, integ_r, integ_s;
  logic [PWM_W-1:0]          base_s;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;

  logic signed [ACC_W-1:0]   acc, lim, neg_lim, clamped;
  logic signed [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]          round_sum;
  logic [RMAG_W-1:0]         rmag;
  logic                      neg;
  logic signed [DRIVE_W-1:0] q, q_l, q_r;

  dwsp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dwsp_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  dwsp_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign in_stall = ctrl.busy;
  assign in_fire  = in_valid && !ctrl.busy;
  assign out_free = !out_valid || !out_stall;

  // Item capture: errors and per-wheel flags.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      err_l    <= {target_left[SPEED_W-1], target_left}
                - {measured_left[SPEED_W-1], measured_left};
      err_r    <= {target_right[SPEED_W-1], target_right}
                - {measured_right[SPEED_W-1], measured_right};
      moving_l <= !target_left[SPEED_W-1] && (target_left[SPEED_W-1:1] != '0);
      moving_r <= !target_right[SPEED_W-1] && (target_right[SPEED_W-1:1] != '0);
      clear_l  <= !target_left[SPEED_W-1] && (target_left[SPEED_W-1:1] != '0)
                  && left_no_edges;
      clear_r  <= !target_right[SPEED_W-1] && (target_right[SPEED_W-1:1] != '0)
                  && right_no_edges;
    end
  end

  assign err_s    = ctrl.wheel ? err_r : err_l;
  assign moving_s = ctrl.wheel ? moving_r : moving_l;
  assign clear_s  = ctrl.wheel ? clear_r : clear_l;
  assign integ_s  = ctrl.wheel ? integ_r : integ_l;
  assign base_s   = ctrl.wheel ? cfg.base_right : cfg.base_left;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.phase)
      ST_MUL_STEP: begin
        mul_a = MUL_A_W'(err_s);
        mul_b = {1'b0, cfg.step_time};
      end
      ST_CLAMP: begin
        mul_a = MUL_A_W'(err_s);
        mul_b = {1'b0, cfg.gain_proportional};
      end
      ST_MUL_INT: begin
        mul_a = integ_s;
        mul_b = {1'b0, cfg.gain_integral};
      end
      default: ;
    endcase
  end

  assign lim     = ACC_W'({1'b0, cfg.integral_limit});
  assign neg_lim = -lim;

  always_comb begin
    if (acc > lim) begin
      clamped = lim;
    end else if (acc < neg_lim) begin
      clamped = neg_lim;
    end else begin
      clamped = acc;
    end
  end

  // Magnitude plus one half; a negative sum is inverted with a carry in.
  assign round_sum = (sum[SUM_W-1] ? ~sum : sum) + HALF_LSB
                   + SUM_W'(sum[SUM_W-1]);

  always_comb begin
    if (!moving_s || rmag == '0) begin
      q = '0;
    end else if (neg) begin
      if (rmag > RMAG_W'(32768)) begin
        q = 16'sh8000;
      end else begin
        q = DRIVE_W'(-rmag[DRIVE_W-1:0]);
      end
    end else if (rmag < RMAG_W'(cfg.pwm_floor)) begin
      q = DRIVE_W'(cfg.pwm_floor);
    end else if (rmag > RMAG_W'(cfg.pwm_ceiling)) begin
      q = DRIVE_W'(cfg.pwm_ceiling);
    end else begin
      q = rmag[DRIVE_W-1:0];
    end
  end

  // Working registers of the datapath.
  always_ff @(posedge clk) begin
    case (ctrl.phase)
      ST_INTEG: begin
        if (clear_s) begin
          acc <= '0;
        end else begin
          acc <= ACC_W'(integ_s) + prod[ACC_W-1:0];
        end
      end
      ST_MUL_INT: begin
        // The proportional product is Q.16; shift it to 32 fraction bits.
        sum <= {12'b0, base_s, 32'b0}
             + {{(SUM_W-50){prod[33]}}, prod[33:0], 16'b0};
      end
      ST_ADD_INT: sum <= sum + SUM_W'(prod);
      ST_ROUND: begin
        rmag <= round_sum[SUM_W-1:32];
        neg  <= sum[SUM_W-1];
      end
      ST_SAT: begin
        if (ctrl.wheel) begin
          q_r <= q;
        end else begin
          q_l <= q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ_l <= '0;
      integ_r <= '0;
    end else if (ctrl.phase == ST_CLAMP) begin
      if (ctrl.wheel) begin
        integ_r <= clamped[INTEG_W-1:0];
      end else begin
        integ_l <= clamped[INTEG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      drive_left  <= q_l;
      drive_right <= q_r;
    end
  end

endmodule
